FILE: src/size_class_block_allocator_top_assert.svh
// Assertion macros for the size class block allocator.
// SCBA_ASSERT_NOW checks the consequent in the same cycle as the antecedent,
// SCBA_ASSERT_NEXT checks it in the next cycle.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SCBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/scba_pkg.sv
`timescale 1ns / 1ps
package scba_pkg;

	// pool geometry
	localparam int NUM_POOLS   = 3;
	localparam int POOL_BLOCKS = 64;
	localparam int CLASS_REGS  = 3;
	localparam int CFG_REGS    = 2 * CLASS_REGS;

	// widths
	localparam int POOL_W     = 2;
	localparam int POS_W      = 6;
	localparam int FILL_W     = $clog2(POOL_BLOCKS + 1);
	localparam int COUNT_W    = 7;
	localparam int BYTES_W    = 32;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = $clog2(CFG_REGS);
	localparam int CFG_DATA_W = 32;
	localparam int RAM_DEPTH  = NUM_POOLS * POOL_BLOCKS;
	localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

	// register map
	localparam int CFG_BYTES_BASE = 0;
	localparam int CFG_COUNT_BASE = CLASS_REGS;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_GRANTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_EXTERNAL = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FREED    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EXT_FREE = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd4;

	localparam logic [POOL_W-1:0] NO_POOL = 2'd3;

	localparam logic [BYTES_W-1:0] RESET_BYTES [CLASS_REGS] = '{32'd4096, 32'd40960, 32'd102400};
	localparam logic [COUNT_W-1:0] RESET_COUNT [CLASS_REGS] = '{7'd50, 7'd10, 7'd5};

	typedef struct packed {
		logic              req_type;
		logic [31:0]       req_size;
		logic [POOL_W-1:0] free_pool;
		logic [POS_W-1:0]  free_block;
	} scba_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POOL_W-1:0]   pool_index;
		logic [POS_W-1:0]    block_index;
	} scba_rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic fin;
	} scba_cmd_t;

	// saturate a count register at the pool capacity
	function automatic logic [FILL_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
		return (c > COUNT_W'(POOL_BLOCKS)) ? FILL_W'(POOL_BLOCKS) : FILL_W'(c);
	endfunction

endpackage

FILE: src/scba_ram.sv
`timescale 1ns / 1ps
module scba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: src/scba_ctrl.sv
`timescale 1ns / 1ps
`include "size_class_block_allocator_top_assert.svh"
module scba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output scba_pkg::scba_cmd_t cmd,
	output logic                done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// issue datapath commands
	always_comb begin
		cmd.load = start && !busy;
		cmd.exec = (state_q == ST_EXEC);
		cmd.fin  = (state_q == ST_FIN);
	end

	// advance through lookup and finish
	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = start ? ST_EXEC : ST_IDLE;
			ST_EXEC: state_d = ST_FIN;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
		end
	end

	`SCBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && cmd.exec,
		"accepted word did not start the lookup")
	`SCBA_ASSERT_NEXT(a_fin_done, clk, arst_n, cmd.fin, done && !busy,
		"finish step did not deliver a result")
	`SCBA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done,
		"result strobe held for more than one cycle")

endmodule

FILE: src/scba_datapath.sv
`timescale 1ns / 1ps
module scba_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scba_pkg::scba_cmd_t                  cmd,
	input  scba_pkg::scba_req_t                  req,
	input  logic                                 cfg_we,
	input  logic [scba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scba_pkg::CFG_DATA_W-1:0]      cfg_data,
	output scba_pkg::scba_rsp_t                  rsp
);

	logic [scba_pkg::BYTES_W-1:0] bytes_q [scba_pkg::CLASS_REGS];
	logic [scba_pkg::COUNT_W-1:0] count_q [scba_pkg::CLASS_REGS];
	logic [scba_pkg::FILL_W-1:0]  fill_q  [scba_pkg::NUM_POOLS];
	logic [scba_pkg::FILL_W-1:0]  low_q   [scba_pkg::NUM_POOLS];
	scba_pkg::scba_req_t          req_q;

	logic [scba_pkg::STATUS_W-1:0] status_s1;
	logic [scba_pkg::POOL_W-1:0]   pool_s1;
	logic                          from_ram_s1;
	logic [scba_pkg::POS_W-1:0]    fresh_s1;
	scba_pkg::scba_rsp_t           rsp_q;

	logic                            fit_found;
	logic [scba_pkg::POOL_W-1:0]     fit_p;
	logic [scba_pkg::FILL_W-1:0]     a_fill;
	logic [scba_pkg::FILL_W-1:0]     a_top;
	logic [scba_pkg::FILL_W-1:0]     a_n;
	logic                            grant;
	logic                            f_valid_pool;
	logic [scba_pkg::POOL_W-1:0]     f_p;
	logic [scba_pkg::FILL_W-1:0]     f_fill;
	logic [scba_pkg::FILL_W-1:0]     f_n;
	logic                            push;
	logic [scba_pkg::STATUS_W-1:0]   status_d;
	logic [scba_pkg::POOL_W-1:0]     op_p;
	logic [scba_pkg::POS_W-1:0]      op_pos;
	logic [scba_pkg::RAM_ADDR_W-1:0] ram_addr;
	logic [scba_pkg::POS_W-1:0]      ram_rdata;

	// hold the accepted request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scba_pkg::CLASS_REGS; i++) begin
				bytes_q[i] <= scba_pkg::RESET_BYTES[i];
				count_q[i] <= scba_pkg::RESET_COUNT[i];
			end
		end else if (cfg_we) begin
			for (int i = 0; i < scba_pkg::CLASS_REGS; i++) begin
				if (cfg_index == scba_pkg::CFG_IDX_W'(scba_pkg::CFG_BYTES_BASE + i)) begin
					bytes_q[i] <= cfg_data;
				end
				if (cfg_index == scba_pkg::CFG_IDX_W'(scba_pkg::CFG_COUNT_BASE + i)) begin
					count_q[i] <= cfg_data[scba_pkg::COUNT_W-1:0];
				end
			end
		end
	end

	// pick the first class that fits, then decide pop or push
	always_comb begin
		fit_found = 1'b0;
		fit_p     = '0;
		for (int p = 0; p < scba_pkg::NUM_POOLS; p++) begin
			if (!fit_found && (req_q.req_size <= bytes_q[p])) begin
				fit_found = 1'b1;
				fit_p     = scba_pkg::POOL_W'(p);
			end
		end
		a_fill = fill_q[fit_p];
		a_top  = a_fill - scba_pkg::FILL_W'(1);
		a_n    = scba_pkg::eff_count(count_q[fit_p]);
		grant  = (req_q.req_type == scba_pkg::REQ_ALLOC) && fit_found &&
			(a_fill != '0);

		f_valid_pool = (req_q.free_pool != scba_pkg::NO_POOL) &&
			(req_q.free_pool < scba_pkg::POOL_W'(scba_pkg::NUM_POOLS));
		f_p    = f_valid_pool ? req_q.free_pool : '0;
		f_fill = fill_q[f_p];
		f_n    = scba_pkg::eff_count(count_q[f_p]);
		push   = (req_q.req_type == scba_pkg::REQ_FREE) && f_valid_pool &&
			(scba_pkg::FILL_W'(req_q.free_block) < f_n) && (f_fill < f_n);

		priority if (req_q.req_type == scba_pkg::REQ_ALLOC) begin
			status_d = grant ? scba_pkg::STAT_GRANTED : scba_pkg::STAT_EXTERNAL;
		end else if (req_q.free_pool == scba_pkg::NO_POOL) begin
			status_d = scba_pkg::STAT_EXT_FREE;
		end else if (push) begin
			status_d = scba_pkg::STAT_FREED;
		end else begin
			status_d = scba_pkg::STAT_REJECTED;
		end

		op_p     = grant ? fit_p : f_p;
		op_pos   = grant ? a_top[scba_pkg::POS_W-1:0] : f_fill[scba_pkg::POS_W-1:0];
		ram_addr = scba_pkg::RAM_ADDR_W'(op_p) * scba_pkg::RAM_ADDR_W'(scba_pkg::POOL_BLOCKS) +
			scba_pkg::RAM_ADDR_W'(op_pos);
	end

	// stack fill and low-water mark: entries below the mark still hold refill values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < scba_pkg::NUM_POOLS; p++) begin
				fill_q[p] <= scba_pkg::eff_count(scba_pkg::RESET_COUNT[p]);
				low_q[p]  <= scba_pkg::eff_count(scba_pkg::RESET_COUNT[p]);
			end
		end else begin
			for (int p = 0; p < scba_pkg::NUM_POOLS; p++) begin
				if (cfg_we &&
					cfg_index == scba_pkg::CFG_IDX_W'(scba_pkg::CFG_COUNT_BASE + p)) begin
					fill_q[p] <= scba_pkg::eff_count(cfg_data[scba_pkg::COUNT_W-1:0]);
					low_q[p]  <= scba_pkg::eff_count(cfg_data[scba_pkg::COUNT_W-1:0]);
				end else if (cmd.exec && grant && fit_p == scba_pkg::POOL_W'(p)) begin
					fill_q[p] <= a_top;
					if (a_top < low_q[p]) begin
						low_q[p] <= a_top;
					end
				end else if (cmd.exec && push && f_p == scba_pkg::POOL_W'(p)) begin
					fill_q[p] <= f_fill + scba_pkg::FILL_W'(1);
				end
			end
		end
	end

	// free-list storage for all pools
	scba_ram #(
		.WIDTH(scba_pkg::POS_W),
		.DEPTH(scba_pkg::RAM_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (cmd.exec && push),
		.addr (ram_addr),
		.wdata(req_q.free_block),
		.rdata(ram_rdata)
	);

	// hold lookup outcome while the read completes
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_s1   <= status_d;
			pool_s1     <= grant ? fit_p : scba_pkg::NO_POOL;
			from_ram_s1 <= (a_top >= low_q[fit_p]);
			fresh_s1    <= scba_pkg::POS_W'(a_n - a_fill);
		end
	end

	// build the result word
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.status     <= status_s1;
			rsp_q.pool_index <= pool_s1;
			if (status_s1 == scba_pkg::STAT_GRANTED) begin
				rsp_q.block_index <= from_ram_s1 ? ram_rdata : fresh_s1;
			end else begin
				rsp_q.block_index <= '0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: src/size_class_block_allocator_top.sv
`timescale 1ns / 1ps
// Fixed-block allocator with three size-class pools, each a LIFO free list of
// block indices. Pulse start with a request word while busy is low; busy stays
// high through the exec and finish steps, and the response word appears on rsp
// with done high for exactly one cycle, once the controller is back in idle.
// The receiver cannot stall, so capture rsp whenever done is high. A new
// request is accepted only in idle: the exec step does the size compare and
// stack update, the finish step takes the registered read of the shared
// free-list RAM, and back in idle the next word is taken. Write configuration
// only while idle; writing a count register refills that pool at once.
module size_class_block_allocator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  scba_pkg::scba_req_t             req,
	output logic                            done,
	output scba_pkg::scba_rsp_t             rsp,
	input  logic                            cfg_we,
	input  logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scba_pkg::CFG_DATA_W-1:0] cfg_data
);

	scba_pkg::scba_cmd_t cmd;

	scba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done)
	);

	scba_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

endmodule

FILE: test/tb_size_class_block_allocator_top.sv
`timescale 1ns / 1ps
module tb_size_class_block_allocator_top;
	import scba_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 185;

	typedef struct packed {
		logic [POOL_W-1:0] pool;
		logic [POS_W-1:0]  block;
	} handle_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	scba_req_t             req       = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	scba_rsp_t             rsp;

	// allocator state as the testbench sees it
	logic [BYTES_W-1:0] class_bytes [NUM_POOLS];
	logic [COUNT_W-1:0] class_count [NUM_POOLS];
	logic [POS_W-1:0]   pool_stack [NUM_POOLS][POOL_BLOCKS];
	int                 pool_fill [NUM_POOLS];

	scba_rsp_t expected_answers [$];
	handle_t   live_blocks [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;

	// directed table
	scba_req_t dir_words [$];
	bit        dir_typed [$];
	scba_rsp_t dir_want [$];

	size_class_block_allocator_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int capped_count(input logic [COUNT_W-1:0] c);
		return (c > POOL_BLOCKS) ? POOL_BLOCKS : int'(c);
	endfunction

	// restack a pool with block 0 on top
	function automatic void refill_pool(input int p);
		int n;
		n = capped_count(class_count[p]);
		for (int i = 0; i < POOL_BLOCKS; i++)
			pool_stack[p][i] = (i < n) ? POS_W'(n - 1 - i) : '0;
		pool_fill[p] = n;
	endfunction

	// answer to one request word, advancing the pool stacks
	function automatic scba_rsp_t predict_answer(input scba_req_t w);
		scba_rsp_t a;
		int        lim;
		bit        fitted;
		a.status      = STAT_EXTERNAL;
		a.pool_index  = NO_POOL;
		a.block_index = '0;
		fitted        = 1'b0;
		if (w.req_type == REQ_ALLOC) begin
			// first fitting class only, no spill to larger pools
			for (int p = 0; p < NUM_POOLS; p++) begin
				if (!fitted && w.req_size <= class_bytes[p]) begin
					fitted = 1'b1;
					if (pool_fill[p] > 0) begin
						pool_fill[p]--;
						a.block_index = pool_stack[p][pool_fill[p]];
						a.pool_index  = POOL_W'(p);
						a.status      = STAT_GRANTED;
					end
				end
			end
		end else if (w.free_pool == NO_POOL) begin
			a.status = STAT_EXT_FREE;
		end else if (w.free_pool >= NUM_POOLS) begin
			a.status = STAT_REJECTED;
		end else begin
			lim = capped_count(class_count[w.free_pool]);
			if (w.free_block >= lim || pool_fill[w.free_pool] >= lim) begin
				a.status = STAT_REJECTED;
			end else begin
				pool_stack[w.free_pool][pool_fill[w.free_pool]] = w.free_block;
				pool_fill[w.free_pool]++;
				a.status = STAT_FREED;
			end
		end
		return a;
	endfunction

	function automatic scba_req_t alloc_word(input logic [31:0] size);
		scba_req_t w;
		w            = '0;
		w.req_type   = REQ_ALLOC;
		w.req_size   = size;
		return w;
	endfunction

	function automatic scba_req_t free_word(input logic [POOL_W-1:0] pool,
			input logic [POS_W-1:0] block);
		scba_req_t w;
		w            = '0;
		w.req_type   = REQ_FREE;
		w.free_pool  = pool;
		w.free_block = block;
		return w;
	endfunction

	function automatic scba_rsp_t answer(input logic [STATUS_W-1:0] st,
			input logic [POOL_W-1:0] pool, input logic [POS_W-1:0] block);
		scba_rsp_t a;
		a.status      = st;
		a.pool_index  = pool;
		a.block_index = block;
		return a;
	endfunction

	task automatic add_row(input scba_req_t w, input bit typed, input scba_rsp_t want);
		dir_words.push_back(w);
		dir_typed.push_back(typed);
		dir_want.push_back(want);
	endtask

	// mostly allocs and frees of granted blocks, some noise frees
	function automatic scba_req_t next_word();
		scba_req_t w;
		int        roll;
		int        k;
		int        p;
		handle_t   h;
		w.req_type   = REQ_ALLOC;
		w.req_size   = $urandom;
		w.free_pool  = POOL_W'($urandom_range(0, 3));
		w.free_block = POS_W'($urandom_range(0, 63));
		roll = $urandom_range(0, 99);
		if (roll < 55 || (roll < 88 && live_blocks.size() == 0)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					p = $urandom_range(0, NUM_POOLS - 1);
					w.req_size = class_bytes[p] + 32'($urandom_range(0, 2)) - 32'd1;
				end
				6, 7: w.req_size = $urandom_range(0, class_bytes[0]);
				8: w.req_size = $urandom;
				default: w.req_size = $urandom_range(0, 1) ? '0 : '1;
			endcase
		end else if (roll < 88) begin
			k = $urandom_range(0, live_blocks.size() - 1);
			h = live_blocks[k];
			// occasionally keep the handle so it gets freed twice
			if ($urandom_range(0, 9) != 0)
				live_blocks.delete(k);
			w.req_type   = REQ_FREE;
			w.free_pool  = h.pool;
			w.free_block = h.block;
		end else begin
			w.req_type = REQ_FREE;
			if ($urandom_range(0, 2) == 0)
				w.free_pool = NO_POOL;
		end
		return w;
	endfunction

	// present one word and hold it until accepted
	task automatic send_word(input scba_req_t w, input bit typed, input scba_rsp_t want);
		scba_rsp_t a;
		handle_t   h;
		start <= 1'b1;
		req   <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		a = predict_answer(w);
		if (a.status == STAT_GRANTED) begin
			h.pool  = a.pool_index;
			h.block = a.block_index;
			live_blocks.push_back(h);
		end
		expected_answers.push_back(typed ? want : a);
	endtask

	task automatic drain_answers();
		start <= 1'b0;
		@(posedge clk);
		while (busy || expected_answers.size() != 0) @(posedge clk);
	endtask

	// register write while idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		int p;
		drain_answers();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < CFG_COUNT_BASE) begin
			class_bytes[idx - CFG_BYTES_BASE] = data;
		end else if (idx < CFG_REGS) begin
			p = idx - CFG_COUNT_BASE;
			class_count[p] = data[COUNT_W-1:0];
			refill_pool(p);
			// outstanding blocks of this pool are forgotten
			for (int i = live_blocks.size() - 1; i >= 0; i--)
				if (live_blocks[i].pool == POOL_W'(p))
					live_blocks.delete(i);
		end
	endtask

	task automatic set_pools(input logic [31:0] b0, b1, b2, c0, c1, c2);
		write_reg(CFG_IDX_W'(CFG_BYTES_BASE + 0), b0);
		write_reg(CFG_IDX_W'(CFG_BYTES_BASE + 1), b1);
		write_reg(CFG_IDX_W'(CFG_BYTES_BASE + 2), b2);
		write_reg(CFG_IDX_W'(CFG_COUNT_BASE + 0), c0);
		write_reg(CFG_IDX_W'(CFG_COUNT_BASE + 1), c1);
		write_reg(CFG_IDX_W'(CFG_COUNT_BASE + 2), c2);
	endtask

	// count value with random bits above the register width
	function automatic logic [31:0] count_word(input int c);
		return ($urandom & 32'hFFFF_FF80) | 32'(c);
	endfunction

	// bursts of words with random gaps, now and then a full drain
	task automatic run_traffic(input int words);
		int n;
		int burst;
		int gap;
		n = 0;
		while (n < words) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && n < words; k++) begin
				send_word(next_word(), 1'b0, '0);
				n++;
			end
			if ($urandom_range(0, 24) == 0)
				drain_answers();
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// check every done word against the oldest expectation
	always @(posedge clk) begin : check_answers
		scba_rsp_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected answer word: status %0d pool %0d block %0d",
						rsp.status, rsp.pool_index, rsp.block_index);
				mismatch_count++;
			end else begin
				want = expected_answers.pop_front();
				if (rsp.status !== want.status || rsp.pool_index !== want.pool_index ||
						rsp.block_index !== want.block_index) begin
					if (mismatch_count < 10)
						$display("answer mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
							want.status, want.pool_index, want.block_index,
							rsp.status, rsp.pool_index, rsp.block_index);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic [31:0] b0;
		logic [31:0] b1;
		for (int p = 0; p < NUM_POOLS; p++) begin
			class_bytes[p] = RESET_BYTES[p];
			class_count[p] = RESET_COUNT[p];
			refill_pool(p);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows against the reset pool setup
		add_row(alloc_word(32'd0), 1, answer(STAT_GRANTED, 2'd0, 6'd0));
		add_row(alloc_word(32'd4096), 1, answer(STAT_GRANTED, 2'd0, 6'd1));
		add_row(alloc_word(32'd4097), 1, answer(STAT_GRANTED, 2'd1, 6'd0));
		add_row(alloc_word(32'd40960), 1, answer(STAT_GRANTED, 2'd1, 6'd1));
		add_row(alloc_word(32'd102400), 1, answer(STAT_GRANTED, 2'd2, 6'd0));
		add_row(alloc_word(32'd102401), 1, answer(STAT_EXTERNAL, NO_POOL, 6'd0));
		add_row(alloc_word(32'hFFFF_FFFF), 1, answer(STAT_EXTERNAL, NO_POOL, 6'd0));
		add_row(free_word(NO_POOL, 6'd63), 1, answer(STAT_EXT_FREE, NO_POOL, 6'd0));
		add_row(free_word(2'd0, 6'd50), 1, answer(STAT_REJECTED, NO_POOL, 6'd0));
		add_row(free_word(2'd0, 6'd63), 1, answer(STAT_REJECTED, NO_POOL, 6'd0));
		add_row(free_word(2'd0, 6'd1), 1, answer(STAT_FREED, NO_POOL, 6'd0));
		add_row(alloc_word(32'd1), 1, answer(STAT_GRANTED, 2'd0, 6'd1));
		add_row(free_word(2'd2, 6'd0), 1, answer(STAT_FREED, NO_POOL, 6'd0));
		// pool 2 is full again
		add_row(free_word(2'd2, 6'd4), 1, answer(STAT_REJECTED, NO_POOL, 6'd0));
		// same block freed twice
		add_row(free_word(2'd1, 6'd0), 0, '0);
		add_row(free_word(2'd1, 6'd0), 0, '0);
		add_row(alloc_word(32'd40000), 0, '0);
		add_row(alloc_word(32'd40000), 0, '0);
		for (int i = 0; i < 5; i++)
			add_row(alloc_word(32'd102400), 0, '0);
		// first fit is empty, no spill
		add_row(alloc_word(32'd50000), 1, answer(STAT_EXTERNAL, NO_POOL, 6'd0));
		add_row(free_word(2'd2, 6'd63), 1, answer(STAT_REJECTED, NO_POOL, 6'd0));

		for (int i = 0; i < dir_words.size(); i++) begin
			send_word(dir_words[i], dir_typed[i], dir_want[i]);
			if (i % 4 == 3) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end

		// random traffic over several pool setups
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				1: set_pools('0, '0, '0, count_word(0), count_word(64), count_word(127));
				2: set_pools('1, 32'd1, 32'd2, count_word(1), count_word(2), count_word(65));
				3: begin
					b0 = $urandom_range(1, 2000);
					b1 = b0 + $urandom_range(0, 30000);
					set_pools(b0, b1, '1, count_word($urandom_range(1, 8)),
						count_word($urandom_range(1, 8)), count_word($urandom_range(1, 8)));
				end
				4: set_pools(32'd100000, 32'd5000, 32'd10, count_word(64), count_word(3),
					count_word(0));
				5: set_pools($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				6: set_pools(RESET_BYTES[0], RESET_BYTES[1], RESET_BYTES[2],
					32'(RESET_COUNT[0]), 32'(RESET_COUNT[1]), 32'(RESET_COUNT[2]));
				default: ;
			endcase
			run_traffic(PHASE_WORDS);
		end

		// let the last answers arrive
		drain_answers();
		repeat (8) @(posedge clk);
		mismatch_count += expected_answers.size();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: size_class_block_allocator_top.f
+incdir+src
src/scba_pkg.sv
src/scba_ram.sv
src/scba_ctrl.sv
src/scba_datapath.sv
src/size_class_block_allocator_top.sv
test/tb_size_class_block_allocator_top.sv
